[hdl/softcode_expression_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// softcode expression tokenizer assertion macros
// clocked assertion helpers shared by the tokenizer modules
// ----------------------------------------------------------------------------
`ifndef SOFTCODE_EXPRESSION_TOKENIZER_MACROS_SVH
`define SOFTCODE_EXPRESSION_TOKENIZER_MACROS_SVH

// property must hold at every edge out of reset
`define STOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define STOK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/stok_pkg.sv]
// ----------------------------------------------------------------------------
// stok_pkg
// token kinds, scan modes and byte classes for the expression tokenizer
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int KIND_W = 4;
  localparam int SLOTS  = 3;   // most tokens one byte can produce
  localparam int DEPTH  = 4;   // token queue entries

  localparam logic [KIND_W-1:0] KIND_LBRACK = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RBRACK = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd5;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_PCT    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_ESC    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_SPACE  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_LIT    = 4'd11;
  localparam logic [KIND_W-1:0] KIND_FUNC   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd13;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_UP_I   = 8'h49;
  localparam logic [7:0] CH_UP_Q   = 8'h51;
  localparam logic [7:0] CH_UP_V   = 8'h56;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_SPACE = 4'd1,
    MODE_LIT   = 4'd2,
    MODE_ESC   = 4'd3,
    MODE_PCT0  = 4'd4,
    MODE_PQ    = 4'd5,
    MODE_PEQ   = 4'd6,
    MODE_PGRP  = 4'd7,
    MODE_PV    = 4'd8,
    MODE_PI    = 4'd9
  } mode_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } single_t;

  function automatic single_t single_kind(input logic [7:0] c);
    single_t r;
    r.hit  = 1'b1;
    r.kind = KIND_LBRACK;
    unique case (c)
      8'h5B: r.kind = KIND_LBRACK;
      8'h5D: r.kind = KIND_RBRACK;
      8'h7B: r.kind = KIND_LBRACE;
      8'h7D: r.kind = KIND_RBRACE;
      8'h28: r.kind = KIND_LPAREN;
      8'h29: r.kind = KIND_RPAREN;
      8'h2C: r.kind = KIND_COMMA;
      8'h3B: r.kind = KIND_SEMI;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
  endfunction

  function automatic logic is_lit_byte(input logic [7:0] c);
    single_t s;
    s = single_kind(c);
    return (c != CH_NUL) && !s.hit && (c != CH_PCT) && (c != CH_BSLASH) && !is_blank(c);
  endfunction

  // kind of a token still open at the end of the text
  function automatic logic [KIND_W-1:0] mode_kind(input mode_t m);
    logic [KIND_W-1:0] k;
    unique case (m)
      MODE_SPACE: k = KIND_SPACE;
      MODE_LIT:   k = KIND_LIT;
      MODE_ESC:   k = KIND_ESC;
      default:    k = KIND_PCT;
    endcase
    return k;
  endfunction

endpackage

[hdl/stok_core.sv]
// ----------------------------------------------------------------------------
// stok_core
// scan state and one-byte step, up to three tokens per request
// ----------------------------------------------------------------------------
`include "softcode_expression_tokenizer_macros.svh"

module stok_core #(
  parameter int MAX_TEXT = 8192,
  parameter int POS_W    = $clog2(MAX_TEXT),
  parameter int LEN_W    = POS_W + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [7:0]                 byte_value,
  input  logic                       byte_present,
  input  logic                       is_last,
  output logic                       tok_vld   [stok_pkg::SLOTS],
  output logic [stok_pkg::KIND_W-1:0] tok_kind [stok_pkg::SLOTS],
  output logic [POS_W-1:0]           tok_start [stok_pkg::SLOTS],
  output logic [LEN_W-1:0]           tok_len   [stok_pkg::SLOTS],
  output logic                       tok_fin   [stok_pkg::SLOTS]
);
  import stok_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_TEXT);
  localparam logic [POS_W-1:0] START_MAX = POS_W'(MAX_TEXT - 1);

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] ps_r, ps_nxt;
  logic [LEN_W-1:0] pl_r, pl_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             stop_r, stop_nxt;

  logic [LEN_W-1:0] len_g;
  logic [POS_W-1:0] pos_sat;
  logic [7:0]       up;
  single_t          sk;
  logic             taken;

  logic             a_v, m_v, d_v;
  logic [KIND_W-1:0] a_kind, m_kind;
  logic [LEN_W-1:0] a_len, m_len;
  logic [POS_W-1:0] m_start, d_start;

  assign len_g   = (pl_r < LEN_MAX) ? (pl_r + 1'b1) : pl_r;
  assign pos_sat = (pos_r > LEN_W'(START_MAX)) ? START_MAX : pos_r[POS_W-1:0];
  assign up      = to_upper(byte_value);
  assign sk      = single_kind(byte_value);

  always_comb begin
    mode_nxt = mode_r;
    ps_nxt   = ps_r;
    pl_nxt   = pl_r;
    pos_nxt  = pos_r;
    stop_nxt = stop_r;
    taken    = 1'b1;
    a_v      = 1'b0;
    a_kind   = KIND_PCT;
    a_len    = pl_r;
    m_v      = 1'b0;
    m_kind   = KIND_LIT;
    m_start  = ps_r;
    m_len    = pl_r;
    d_v      = 1'b0;
    d_start  = '0;

    if (byte_present && !stop_r) begin
      unique case (mode_r)
        MODE_SPACE: begin
          if (is_blank(byte_value)) begin
            pl_nxt = len_g;
          end else begin
            a_v = 1'b1; a_kind = KIND_SPACE; mode_nxt = MODE_IDLE; taken = 1'b0;
          end
        end
        MODE_LIT: begin
          if (is_lit_byte(byte_value)) begin
            pl_nxt = len_g;
          end else begin
            a_v = 1'b1; mode_nxt = MODE_IDLE; taken = 1'b0;
            a_kind = (byte_value == CH_LPAREN) ? KIND_FUNC : KIND_LIT;
          end
        end
        MODE_ESC: begin
          a_v = 1'b1; a_kind = KIND_ESC; mode_nxt = MODE_IDLE;
          if (byte_value != CH_NUL) begin
            pl_nxt = len_g; a_len = len_g;
          end else begin
            taken = 1'b0;
          end
        end
        MODE_PCT0: begin
          pl_nxt = len_g;
          priority if (up == CH_UP_Q || up == CH_UP_C || up == CH_UP_X) mode_nxt = MODE_PQ;
          else if (byte_value == CH_EQ) mode_nxt = MODE_PEQ;
          else if (up == CH_UP_V) mode_nxt = MODE_PV;
          else if (up == CH_UP_I) mode_nxt = MODE_PI;
          else begin
            a_v = 1'b1; a_len = len_g; mode_nxt = MODE_IDLE;
          end
        end
        MODE_PQ: begin
          pl_nxt = len_g;
          if (byte_value == CH_LT) begin
            mode_nxt = MODE_PGRP;
          end else begin
            a_v = 1'b1; a_len = len_g; mode_nxt = MODE_IDLE;
          end
        end
        MODE_PEQ: begin
          if (byte_value == CH_LT) begin
            pl_nxt = len_g; mode_nxt = MODE_PGRP;
          end else begin
            a_v = 1'b1; mode_nxt = MODE_IDLE; taken = 1'b0;
          end
        end
        MODE_PGRP: begin
          pl_nxt = len_g;
          if (byte_value == CH_GT) begin
            a_v = 1'b1; a_len = len_g; mode_nxt = MODE_IDLE;
          end
        end
        MODE_PV: begin
          a_v = 1'b1; mode_nxt = MODE_IDLE;
          if (is_alpha(byte_value)) begin
            pl_nxt = len_g; a_len = len_g;
          end else begin
            taken = 1'b0;
          end
        end
        MODE_PI: begin
          a_v = 1'b1; mode_nxt = MODE_IDLE;
          if (is_digit(byte_value)) begin
            pl_nxt = len_g; a_len = len_g;
          end else begin
            taken = 1'b0;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE; taken = 1'b0;
        end
      endcase

      if (!taken) begin
        priority if (byte_value == CH_NUL) begin
          stop_nxt = 1'b1;
        end else if (sk.hit) begin
          m_v = 1'b1; m_kind = sk.kind; m_start = pos_sat; m_len = LEN_W'(1);
        end else if (byte_value == CH_PCT) begin
          mode_nxt = MODE_PCT0; ps_nxt = pos_sat; pl_nxt = LEN_W'(1);
        end else if (byte_value == CH_BSLASH) begin
          mode_nxt = MODE_ESC; ps_nxt = pos_sat; pl_nxt = LEN_W'(1);
        end else if (is_blank(byte_value)) begin
          mode_nxt = MODE_SPACE; ps_nxt = pos_sat; pl_nxt = LEN_W'(1);
        end else begin
          mode_nxt = MODE_LIT; ps_nxt = pos_sat; pl_nxt = LEN_W'(1);
        end
      end
    end

    if (byte_present && (pos_r < LEN_MAX)) pos_nxt = pos_r + 1'b1;

    if (is_last) begin
      if (mode_nxt != MODE_IDLE) begin
        m_v = 1'b1; m_kind = mode_kind(mode_nxt); m_start = ps_nxt; m_len = pl_nxt;
      end
      d_v     = 1'b1;
      d_start = (pos_nxt > LEN_W'(START_MAX)) ? START_MAX : pos_nxt[POS_W-1:0];
      mode_nxt = MODE_IDLE;
      ps_nxt   = '0;
      pl_nxt   = '0;
      pos_nxt  = '0;
      stop_nxt = 1'b0;
    end
  end

  // slot 0: token closed by this byte, slot 1: single or tail token, slot 2: end
  always_comb begin
    tok_vld[0]   = step && a_v;
    tok_kind[0]  = a_kind;
    tok_start[0] = ps_r;
    tok_len[0]   = a_len;
    tok_fin[0]   = 1'b0;
    tok_vld[1]   = step && m_v;
    tok_kind[1]  = m_kind;
    tok_start[1] = m_start;
    tok_len[1]   = m_len;
    tok_fin[1]   = 1'b0;
    tok_vld[2]   = step && d_v;
    tok_kind[2]  = KIND_END;
    tok_start[2] = d_start;
    tok_len[2]   = '0;
    tok_fin[2]   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      ps_r   <= '0;
      pl_r   <= '0;
      pos_r  <= '0;
      stop_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      ps_r   <= ps_nxt;
      pl_r   <= pl_nxt;
      pos_r  <= pos_nxt;
      stop_r <= stop_nxt;
    end
  end

  `STOK_ASSERT(a_stop_idle, stop_r |-> (mode_r == MODE_IDLE), "stopped scan left a token open")
  `STOK_ASSERT(a_last_clears, (step && is_last) |=> (mode_r == MODE_IDLE && pos_r == '0 && !stop_r), "state not cleared after end of text")

endmodule

[hdl/stok_fifo.sv]
// ----------------------------------------------------------------------------
// stok_fifo
// small token queue, takes up to three tokens a cycle, gives one while out_stall is low
// ----------------------------------------------------------------------------
`include "softcode_expression_tokenizer_macros.svh"

module stok_fifo #(
  parameter int MAX_TEXT = 8192,
  parameter int POS_W    = $clog2(MAX_TEXT),
  parameter int LEN_W    = POS_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_vld   [stok_pkg::SLOTS],
  input  logic [stok_pkg::KIND_W-1:0] push_kind  [stok_pkg::SLOTS],
  input  logic [POS_W-1:0]            push_start [stok_pkg::SLOTS],
  input  logic [LEN_W-1:0]            push_len   [stok_pkg::SLOTS],
  input  logic                        push_fin   [stok_pkg::SLOTS],
  output logic                        space_ok,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stok_pkg::KIND_W-1:0] out_kind,
  output logic [POS_W-1:0]            out_start,
  output logic [LEN_W-1:0]            out_len,
  output logic                        out_fin
);
  import stok_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [KIND_W-1:0] mem_kind  [DEPTH];
  logic [POS_W-1:0]  mem_start [DEPTH];
  logic [LEN_W-1:0]  mem_len   [DEPTH];
  logic              mem_fin   [DEPTH];

  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] widx [SLOTS];
  logic [CNT_W-1:0] push_n;
  logic             pop;

  // each valid slot lands after the valid slots ahead of it
  always_comb begin
    push_n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      widx[i] = wptr_r + push_n[PTR_W-1:0];
      if (push_vld[i]) push_n = push_n + 1'b1;
    end
  end

  assign pop       = (count_r != '0) && !out_stall;
  assign wptr_nxt  = wptr_r + push_n[PTR_W-1:0];
  assign rptr_nxt  = rptr_r + PTR_W'(pop);
  assign count_nxt = count_r + push_n - CNT_W'(pop);
  assign space_ok  = count_r <= CNT_W'(DEPTH - SLOTS);

  assign out_valid = count_r != '0;
  assign out_kind  = mem_kind[rptr_r];
  assign out_start = mem_start[rptr_r];
  assign out_len   = mem_len[rptr_r];
  assign out_fin   = mem_fin[rptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (push_vld[i]) begin
        mem_kind[widx[i]]  <= push_kind[i];
        mem_start[widx[i]] <= push_start[i];
        mem_len[widx[i]]   <= push_len[i];
        mem_fin[widx[i]]   <= push_fin[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  `STOK_NEVER(a_no_overflow, count_r > CNT_W'(DEPTH), "token queue overflow")
  `STOK_ASSERT(a_push_room, (push_n != '0) |-> space_ok, "tokens pushed without room")

endmodule

[hdl/softcode_expression_tokenizer.sv]
// ----------------------------------------------------------------------------
// softcode_expression_tokenizer
// streaming tokenizer for softcode expression text, one byte per request
// ----------------------------------------------------------------------------
//
//  channel  | ports                                               | direction
//  ---------+-----------------------------------------------------+----------
//  in       | in_valid in_stall in_byte_value in_byte_present     | sink
//           | in_is_last                                          |
//  out      | out_valid out_stall out_token_kind out_token_start  | source
//           | out_token_length out_final_token                    |
//
//  one byte request is taken per cycle while in_stall is low; its tokens reach the output queue on
//  the same edge and the first can leave on the next cycle
//  a byte may yield up to three tokens, and they leave the output one at a time;
//  in_stall rises while the four-entry token queue has more than one entry
//  out_stall backs up the token queue, and the scan state waits on it through in_stall
//  synchronous active-low reset clears scan state and the queue, no sweep
//
`include "softcode_expression_tokenizer_macros.svh"

module softcode_expression_tokenizer #(
  parameter int MAX_TEXT = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte_value,
  input  logic                                in_byte_present,
  input  logic                                in_is_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stok_pkg::KIND_W-1:0]         out_token_kind,
  output logic [$clog2(MAX_TEXT)-1:0]         out_token_start,
  output logic [$clog2(MAX_TEXT):0]           out_token_length,
  output logic                                out_final_token
);
  import stok_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT);
  localparam int LEN_W = POS_W + 1;

  // request handshake on the byte side
  logic accept;
  logic space_ok;

  // tokens produced by the current byte, in emission order
  logic              tok_vld   [SLOTS];
  logic [KIND_W-1:0] tok_kind  [SLOTS];
  logic [POS_W-1:0]  tok_start [SLOTS];
  logic [LEN_W-1:0]  tok_len   [SLOTS];
  logic              tok_fin   [SLOTS];

  // queue must be able to absorb a worst-case byte before taking one
  assign in_stall = !space_ok;
  assign accept   = in_valid && space_ok;

  // scan state machine: mode, open token start and length, text position
  stok_core #(
    .MAX_TEXT (MAX_TEXT),
    .POS_W    (POS_W),
    .LEN_W    (LEN_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .byte_value   (in_byte_value),
    .byte_present (in_byte_present),
    .is_last      (in_is_last),
    .tok_vld      (tok_vld),
    .tok_kind     (tok_kind),
    .tok_start    (tok_start),
    .tok_len      (tok_len),
    .tok_fin      (tok_fin)
  );

  // output queue decouples the token side from the byte side
  stok_fifo #(
    .MAX_TEXT (MAX_TEXT),
    .POS_W    (POS_W),
    .LEN_W    (LEN_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_vld   (tok_vld),
    .push_kind  (tok_kind),
    .push_start (tok_start),
    .push_len   (tok_len),
    .push_fin   (tok_fin),
    .space_ok   (space_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_token_kind),
    .out_start  (out_token_start),
    .out_len    (out_token_length),
    .out_fin    (out_final_token)
  );

endmodule
